// File: rtl/jd2c_pkg.sv
// Shared constants, widths, types and the month-offset table for the
// Julian time to civil date and time converter.
// No dependencies; every rtl module imports this package.
`default_nettype none

package jd2c_pkg;

  // Input time width; the day-number datapath widths below follow from it (36..48)
  localparam int TIME_WIDTH = 40;

  // Civil-time split: seconds + half day, then divide by 86400 = 128 * 675
  localparam int CIV_W    = TIME_WIDTH + 1;
  localparam int X_W      = CIV_W - 7;
  localparam int XL_W     = X_W / 2;
  localparam int XH_W     = X_W - XL_W;
  localparam int Z_W      = TIME_WIDTH - 16;
  localparam int TOD_W    = 17;
  localparam int HALF_DAY = 43200;
  localparam int DAY_DIV  = 675;
  localparam int DAY_REM_W = 11;
  localparam longint unsigned DAY_M = (64'd1 << X_W) / 64'd675;
  localparam int DM_W     = X_W - 9;
  localparam int PH_W     = XH_W + DM_W;
  localparam int PL_W     = XL_W + DM_W;
  localparam int PS_W     = X_W + DM_W;

  // Gregorian correction: alpha = (4z - 7468865) / 146097
  localparam int GREG_START = 2299161;
  localparam int GREG_OFS   = 7468865;
  localparam int ALPHA_DIV  = 146097;
  localparam int GN_W       = Z_W + 2;
  localparam longint unsigned GA_M = (64'd1 << GN_W) / 64'd146097;
  localparam int GAM_W      = GN_W - 17;
  localparam int GAP_W      = GN_W + GAM_W;
  localparam int ALPHA_REM_W = 19;

  // Year count: c = (20b - 2442) / 7305
  localparam int B_OFS    = 1524;
  localparam int B_W      = Z_W + 1;
  localparam int CN_W     = B_W + 5;
  localparam int CYC_OFS  = 2442;
  localparam int CYC_DIV  = 7305;
  localparam longint unsigned C_M = (64'd1 << CN_W) / 64'd7305;
  localparam int C_W      = CN_W - 12;
  localparam int CP_W     = CN_W + C_W;
  localparam int CYC_REM_W = 14;
  localparam int D_W      = C_W + 11;
  localparam int DAYS_4Y  = 1461;

  // Month count: e = 10000 (b - d) / 306001
  localparam int BD_W     = 9;
  localparam int EX_W     = 23;
  localparam int EP_W     = 27;
  localparam int E_W      = 4;
  localparam int MON_SCALE = 10000;
  localparam int MON_PROD = 270000;
  localparam int MON_DIV  = 306001;
  localparam int MON_K    = 23;

  // Year offsets for early (Jan, Feb) and late months
  localparam int YEAR_OFS_LATE  = 4716;
  localparam int YEAR_OFS_EARLY = 4715;

  // Division by 15 for minutes and hours (x < 2^15)
  localparam int DIV15_M  = 2184;
  localparam int DIV15_K  = 15;
  localparam int TP_W     = 27;
  localparam int HP_W     = 21;
  localparam int MT_W     = 11;

  // Weekday: day number mod 7 through octal digit sums
  localparam int WD_DIGITS = (Z_W + 2) / 3;
  localparam int ZX_W      = WD_DIGITS * 3;
  localparam int WSUM_W    = 7;

  // Pipeline depth: three stages in the day split, nine after it
  localparam int SPLIT_DEPTH = 3;
  localparam int PIPE_DEPTH  = 12;

  typedef struct packed {
    logic [Z_W-1:0]   day_num;
    logic [TOD_W-1:0] tod;
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } clock_t;

  // floor(30.6001 * e) for the month index e
  function automatic logic [BD_W-1:0] month_days(input logic [E_W-1:0] e);
    logic [BD_W-1:0] v;
    unique case (e)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd30;
      4'd2:  v = 9'd61;
      4'd3:  v = 9'd91;
      4'd4:  v = 9'd122;
      4'd5:  v = 9'd153;
      4'd6:  v = 9'd183;
      4'd7:  v = 9'd214;
      4'd8:  v = 9'd244;
      4'd9:  v = 9'd275;
      4'd10: v = 9'd306;
      4'd11: v = 9'd336;
      4'd12: v = 9'd367;
      4'd13: v = 9'd397;
      4'd14: v = 9'd428;
      4'd15: v = 9'd459;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jd2c_daysplit.sv
// Three-stage split of the input time into civil day number and time of day.
// Depends on jd2c_pkg (widths, reciprocal of 675, split_t).
`default_nettype none

module jd2c_daysplit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [jd2c_pkg::TIME_WIDTH-1:0] in_seconds,
  output logic                          out_valid,
  output jd2c_pkg::split_t              out_split
);
  import jd2c_pkg::*;

  logic [CIV_W-1:0] civil;
  logic [X_W-1:0]   x;
  logic [PH_W-1:0]  ph_nxt, ph_r;
  logic [PL_W-1:0]  pl_nxt, pl_r;
  logic [X_W-1:0]   x1_r, x2_r;
  logic [6:0]       lo1_r, lo2_r;
  logic             v1_r, v2_r, v3_r;
  logic [PS_W-1:0]  psum;
  logic [Z_W-1:0]   q0_nxt, q0_r;
  logic [X_W-1:0]   rem_full;
  logic [DAY_REM_W-1:0] rem;
  logic [DAY_REM_W-1:0] rem_fix;
  split_t           split_nxt, split_r;

  // Shift to civil midnight, drop the factor 128, form partial products
  always_comb begin
    civil  = CIV_W'(in_seconds) + CIV_W'(HALF_DAY);
    x      = civil[CIV_W-1:7];
    ph_nxt = PH_W'(x[X_W-1:XL_W]) * PH_W'(DM_W'(DAY_M));
    pl_nxt = PL_W'(x[XL_W-1:0]) * PL_W'(DM_W'(DAY_M));
  end

  // Combine partial products into the quotient estimate
  always_comb begin
    psum   = (PS_W'(ph_r) << XL_W) + PS_W'(pl_r);
    q0_nxt = psum[X_W+Z_W-1:X_W];
  end

  // Correct the estimate by one and rebuild the time of day
  always_comb begin
    rem_full = x2_r - X_W'(q0_r) * X_W'(DAY_DIV);
    rem      = rem_full[DAY_REM_W-1:0];
    if (rem >= DAY_REM_W'(DAY_DIV)) begin
      split_nxt.day_num = q0_r + Z_W'(1);
      rem_fix           = rem - DAY_REM_W'(DAY_DIV);
    end else begin
      split_nxt.day_num = q0_r;
      rem_fix           = rem;
    end
    split_nxt.tod = {rem_fix[9:0], lo2_r};
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    pl_r    <= pl_nxt;
    x1_r    <= x;
    lo1_r   <= civil[6:0];
    q0_r    <= q0_nxt;
    x2_r    <= x1_r;
    lo2_r   <= lo1_r;
    split_r <= split_nxt;
  end

  assign out_valid = v3_r;
  assign out_split = split_r;

endmodule

`default_nettype wire

// File: rtl/julian_date_to_civil_datetime.sv
// Top level: pipelined Julian seconds to civil date, time and weekday.
// Depends on jd2c_pkg and jd2c_daysplit.
//
//   channel  ports                                   transfer when
//   input    start, busy, in_julian_seconds          start && !busy
//   result   out_valid, out_year .. out_weekday      out_valid (one cycle)
//
// One item enters per cycle; busy is always low.
// Results appear in the order of their input transfers.
// The pipeline is a chain of reciprocal multiplies with correction:
// day split (3 stages), alpha, year count and month count stages.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing is ever held back.
`default_nettype none

module julian_date_to_civil_datetime (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [jd2c_pkg::TIME_WIDTH-1:0] in_julian_seconds,
  output logic                            out_valid,
  output logic signed [15:0]              out_year,
  output logic [3:0]                      out_month,
  output logic [4:0]                      out_day,
  output logic [4:0]                      out_hour,
  output logic [5:0]                      out_minute,
  output logic [5:0]                      out_second,
  output logic [2:0]                      out_weekday
);
  import jd2c_pkg::*;

  logic   ds_valid;
  split_t ds_split;
  logic [PIPE_DEPTH:SPLIT_DEPTH+1] vld_r;

  // Stage 4
  logic [Z_W-1:0]    z4_r;
  logic [TOD_W-1:0]  tod4_r;
  logic              greg4_nxt, greg4_r;
  logic [GN_W-1:0]   gan4_nxt, gan4_r;
  logic [GAP_W-1:0]  gap4_nxt, gap4_r;
  logic [TP_W-1:0]   tp4_nxt, tp4_r;
  logic [ZX_W-1:0]   zx;
  logic [WSUM_W-1:0] wsum4_nxt, wsum4_r;

  // Stage 5
  logic [Z_W-1:0]    z5_r;
  logic [TOD_W-1:0]  tod5_r;
  logic              greg5_r;
  logic [GAM_W-1:0]  aq0;
  logic [GN_W-1:0]   arem;
  logic [GAM_W-1:0]  alpha5_nxt, alpha5_r;
  logic [MT_W-1:0]   mq0;
  logic [14:0]       mrem;
  logic [MT_W-1:0]   mt5_nxt, mt5_r;
  logic [3:0]        wfold;
  logic [2:0]        wmod;
  logic [2:0]        wd5_nxt, wd5_r;

  // Stage 6
  logic [B_W-1:0]    a6;
  logic [B_W-1:0]    b6_nxt, b6_r;
  logic [CN_W-1:0]   cn6_nxt, cn6_r;
  logic [MT_W-1:0]   mt6_r;
  logic [TOD_W-1:0]  srem;
  logic [5:0]        sec6_nxt, sec6_r;
  logic [HP_W-1:0]   hp6_nxt, hp6_r;
  logic [2:0]        wd6_r;

  // Stage 7
  logic [B_W-1:0]    b7_r;
  logic [CN_W-1:0]   cn7_r;
  logic [CP_W-1:0]   cp7_nxt, cp7_r;
  logic [4:0]        hq0;
  logic [8:0]        hrem;
  logic [4:0]        hour7;
  logic [MT_W-1:0]   minrem;
  clock_t            clk7_nxt, clk7_r;

  // Stage 8
  logic [C_W-1:0]    cq0;
  logic [CN_W-1:0]   crem;
  logic [C_W-1:0]    c8_nxt, c8_r;
  logic [B_W-1:0]    b8_r;
  clock_t            clk8_r;

  // Stage 9
  logic [D_W-1:0]    dprod;
  logic [B_W-1:0]    bdfull;
  logic [BD_W-1:0]   bd9_nxt, bd9_r;
  logic [C_W-1:0]    c9_r;
  clock_t            clk9_r;

  // Stage 10
  logic [EX_W-1:0]   ex10_nxt, ex10_r;
  logic [EP_W-1:0]   ep10_nxt, ep10_r;
  logic [BD_W-1:0]   bd10_r;
  logic [C_W-1:0]    c10_r;
  clock_t            clk10_r;

  // Stage 11
  logic [E_W-1:0]    eq0;
  logic [EX_W-1:0]   erem;
  logic [E_W-1:0]    e11_nxt, e11_r;
  logic [BD_W-1:0]   bd11_r;
  logic [C_W-1:0]    c11_r;
  clock_t            clk11_r;

  // Stage 12 (outputs)
  logic [BD_W-1:0]   dfull;
  logic [3:0]        month_nxt, month_r;
  logic [4:0]        day_nxt, day_r;
  logic signed [31:0] year_full;
  logic signed [15:0] year_nxt, year_r;
  clock_t            clk12_r;

  assign busy = 1'b0;

  jd2c_daysplit u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .in_seconds (in_julian_seconds),
    .out_valid  (ds_valid),
    .out_split  (ds_split)
  );

  // Stage 4: alpha numerator and product, minute product, weekday digit sum
  always_comb begin
    greg4_nxt = (32'(ds_split.day_num) >= 32'(GREG_START));
    gan4_nxt  = {ds_split.day_num, 2'b00} - GN_W'(GREG_OFS);
    gap4_nxt  = GAP_W'(gan4_nxt) * GAP_W'(GAM_W'(GA_M));
    tp4_nxt   = TP_W'(ds_split.tod[TOD_W-1:2]) * TP_W'(DIV15_M);
    zx        = ZX_W'(ds_split.day_num);
    wsum4_nxt = '0;
    for (int i = 0; i < WD_DIGITS; i++) begin
      wsum4_nxt = wsum4_nxt + WSUM_W'(zx[3*i +: 3]);
    end
  end

  // Stage 5: correct alpha and total minutes, reduce weekday mod 7
  always_comb begin
    aq0  = gap4_r[GAP_W-1:GN_W];
    arem = gan4_r - GN_W'(aq0) * GN_W'(ALPHA_DIV);
    if (arem[ALPHA_REM_W-1:0] >= ALPHA_REM_W'(ALPHA_DIV)) begin
      alpha5_nxt = aq0 + GAM_W'(1);
    end else begin
      alpha5_nxt = aq0;
    end

    mq0  = tp4_r[DIV15_K+MT_W-1:DIV15_K];
    mrem = tod4_r[TOD_W-1:2] - 15'(mq0) * 15'(15);
    if (mrem[4:0] >= 5'd15) begin
      mt5_nxt = mq0 + MT_W'(1);
    end else begin
      mt5_nxt = mq0;
    end

    wfold = 4'(wsum4_r[2:0]) + 4'(wsum4_r[5:3]) + 4'(wsum4_r[6]);
    if (wfold >= 4'd14) begin
      wmod = 3'(wfold - 4'd14);
    end else if (wfold >= 4'd7) begin
      wmod = 3'(wfold - 4'd7);
    end else begin
      wmod = wfold[2:0];
    end
    // The civil weekday is one ahead of the day number mod 7
    wd5_nxt = (wmod == 3'd6) ? 3'd0 : wmod + 3'd1;
  end

  // Stage 6: calendar base b and year numerator, seconds, hour product
  always_comb begin
    if (greg5_r) begin
      a6 = B_W'(z5_r) + B_W'(1) + B_W'(alpha5_r) - B_W'(alpha5_r >> 2);
    end else begin
      a6 = B_W'(z5_r);
    end
    b6_nxt   = a6 + B_W'(B_OFS);
    cn6_nxt  = (CN_W'(b6_nxt) << 4) + (CN_W'(b6_nxt) << 2) - CN_W'(CYC_OFS);
    srem     = tod5_r - TOD_W'(mt5_r) * TOD_W'(60);
    sec6_nxt = srem[5:0];
    hp6_nxt  = HP_W'(mt5_r[MT_W-1:2]) * HP_W'(DIV15_M);
  end

  // Stage 7: year product, correct hours, minutes
  always_comb begin
    cp7_nxt = CP_W'(cn6_r) * CP_W'(C_W'(C_M));
    hq0     = hp6_r[DIV15_K+4:DIV15_K];
    hrem    = mt6_r[MT_W-1:2] - 9'(hq0) * 9'(15);
    if (hrem[4:0] >= 5'd15) begin
      hour7 = hq0 + 5'd1;
    end else begin
      hour7 = hq0;
    end
    minrem           = mt6_r - MT_W'(hour7) * MT_W'(60);
    clk7_nxt.hour    = hour7;
    clk7_nxt.minute  = minrem[5:0];
    clk7_nxt.second  = sec6_r;
    clk7_nxt.weekday = wd6_r;
  end

  // Stage 8: correct the year count
  always_comb begin
    cq0  = cp7_r[CP_W-1:CN_W];
    crem = cn7_r - CN_W'(cq0) * CN_W'(CYC_DIV);
    if (crem[CYC_REM_W-1:0] >= CYC_REM_W'(CYC_DIV)) begin
      c8_nxt = cq0 + C_W'(1);
    end else begin
      c8_nxt = cq0;
    end
  end

  // Stage 9: days into the year count
  always_comb begin
    dprod   = D_W'(c8_r) * D_W'(DAYS_4Y);
    bdfull  = b8_r - B_W'(dprod >> 2);
    bd9_nxt = bdfull[BD_W-1:0];
  end

  // Stage 10: month numerator and its reciprocal product
  always_comb begin
    ex10_nxt = EX_W'(bd9_r) * EX_W'(MON_SCALE);
    ep10_nxt = EP_W'(bd9_r) * EP_W'(MON_PROD);
  end

  // Stage 11: correct the month index
  always_comb begin
    eq0  = ep10_r[MON_K+E_W-1:MON_K];
    erem = ex10_r - EX_W'(eq0) * EX_W'(MON_DIV);
    if (erem >= EX_W'(MON_DIV)) begin
      e11_nxt = eq0 + E_W'(1);
    end else begin
      e11_nxt = eq0;
    end
  end

  // Stage 12: day, month and year
  always_comb begin
    dfull   = bd11_r - month_days(e11_r);
    day_nxt = dfull[4:0];
    if (e11_r < 4'd14) begin
      month_nxt = e11_r - 4'd1;
    end else begin
      month_nxt = e11_r - 4'd13;
    end
    if (month_nxt > 4'd2) begin
      year_full = $signed(32'(c11_r)) - 32'(YEAR_OFS_LATE);
    end else begin
      year_full = $signed(32'(c11_r)) - 32'(YEAR_OFS_EARLY);
    end
    year_nxt = year_full[15:0];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-1:SPLIT_DEPTH+1], ds_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    z4_r     <= ds_split.day_num;
    tod4_r   <= ds_split.tod;
    greg4_r  <= greg4_nxt;
    gan4_r   <= gan4_nxt;
    gap4_r   <= gap4_nxt;
    tp4_r    <= tp4_nxt;
    wsum4_r  <= wsum4_nxt;

    z5_r     <= z4_r;
    tod5_r   <= tod4_r;
    greg5_r  <= greg4_r;
    alpha5_r <= alpha5_nxt;
    mt5_r    <= mt5_nxt;
    wd5_r    <= wd5_nxt;

    b6_r     <= b6_nxt;
    cn6_r    <= cn6_nxt;
    mt6_r    <= mt5_r;
    sec6_r   <= sec6_nxt;
    hp6_r    <= hp6_nxt;
    wd6_r    <= wd5_r;

    b7_r     <= b6_r;
    cn7_r    <= cn6_r;
    cp7_r    <= cp7_nxt;
    clk7_r   <= clk7_nxt;

    b8_r     <= b7_r;
    c8_r     <= c8_nxt;
    clk8_r   <= clk7_r;

    bd9_r    <= bd9_nxt;
    c9_r     <= c8_r;
    clk9_r   <= clk8_r;

    ex10_r   <= ex10_nxt;
    ep10_r   <= ep10_nxt;
    bd10_r   <= bd9_r;
    c10_r    <= c9_r;
    clk10_r  <= clk9_r;

    e11_r    <= e11_nxt;
    bd11_r   <= bd10_r;
    c11_r    <= c10_r;
    clk11_r  <= clk10_r;

    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    clk12_r  <= clk11_r;
  end

  assign out_valid   = vld_r[PIPE_DEPTH];
  assign out_year    = year_r;
  assign out_month   = month_r;
  assign out_day     = day_r;
  assign out_hour    = clk12_r.hour;
  assign out_minute  = clk12_r.minute;
  assign out_second  = clk12_r.second;
  assign out_weekday = clk12_r.weekday;

endmodule

`default_nettype wire

// File: rtl/jd2c_check.sv
// Port-level checker for the converter, bound to the top level.
// Depends on jd2c_pkg (pipeline depth).
`default_nettype none

module jd2c_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [jd2c_pkg::TIME_WIDTH-1:0] in_julian_seconds,
  input logic                            out_valid,
  input logic signed [15:0]              out_year,
  input logic [3:0]                      out_month,
  input logic [4:0]                      out_day,
  input logic [4:0]                      out_hour,
  input logic [5:0]                      out_minute,
  input logic [5:0]                      out_second,
  input logic [2:0]                      out_weekday
);
  import jd2c_pkg::*;

  // Every input transfer yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("result missing after input transfer");

  // No result without a matching input transfer
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without input transfer");

  // Result fields stay in their calendar ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day >= 5'd1 && out_day <= 5'd31 &&
                   out_hour <= 5'd23 && out_minute <= 6'd59 &&
                   out_second <= 6'd59 && out_weekday <= 3'd6))
    else $error("result field out of range");

  // Reset drops everything in flight
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind julian_date_to_civil_datetime jd2c_check u_jd2c_check (.*);

`default_nettype wire
